@@ rtl/amst_pkg.sv @@
`timescale 1ns / 1ps

package amst_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;

  localparam int ELEM_W  = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // exact product width and the width of the rounded sum of two products
  localparam int PROD_W = 2 * ELEM_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLW = 2'd2;
  localparam logic [STAT_W-1:0] ST_SAT      = 2'd3;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(STACK_DEPTH);

  localparam logic signed [ELEM_W-1:0] FX_ONE  = ELEM_W'(1) << FRAC_BITS;
  localparam logic signed [ELEM_W-1:0] FX_ZERO = '0;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    elem_t a;
    elem_t b;
    elem_t c;
    elem_t d;
    elem_t tx;
    elem_t ty;
  } mat_t;

  localparam mat_t MAT_IDENTITY = '{a: FX_ONE, b: FX_ZERO, c: FX_ZERO, d: FX_ONE,
                                    tx: FX_ZERO, ty: FX_ZERO};

endpackage

@@ rtl/amst_cmd_if.sv @@
`timescale 1ns / 1ps

interface amst_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [amst_pkg::CMD_W-1:0]   cmd;
  logic signed [amst_pkg::ELEM_W-1:0] in_a;
  logic signed [amst_pkg::ELEM_W-1:0] in_b;
  logic signed [amst_pkg::ELEM_W-1:0] in_c;
  logic signed [amst_pkg::ELEM_W-1:0] in_d;
  logic signed [amst_pkg::ELEM_W-1:0] in_tx;
  logic signed [amst_pkg::ELEM_W-1:0] in_ty;

  modport source (output valid, cmd, in_a, in_b, in_c, in_d, in_tx, in_ty, input ready);
  modport sink   (input valid, cmd, in_a, in_b, in_c, in_d, in_tx, in_ty, output ready);
endinterface

@@ rtl/amst_res_if.sv @@
`timescale 1ns / 1ps

interface amst_res_if;
  logic                          valid;
  logic                          ready;
  logic signed [amst_pkg::ELEM_W-1:0] out_a;
  logic signed [amst_pkg::ELEM_W-1:0] out_b;
  logic signed [amst_pkg::ELEM_W-1:0] out_c;
  logic signed [amst_pkg::ELEM_W-1:0] out_d;
  logic signed [amst_pkg::ELEM_W-1:0] out_tx;
  logic signed [amst_pkg::ELEM_W-1:0] out_ty;
  logic [amst_pkg::LEVEL_W-1:0]  level;
  logic [amst_pkg::STAT_W-1:0]   status;

  modport source (output valid, out_a, out_b, out_c, out_d, out_tx, out_ty, level, status,
                  input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, out_tx, out_ty, level, status,
                  output ready);
endinterface

@@ rtl/amst_dot2.sv @@
`timescale 1ns / 1ps

// round((x1*y1 + x2*y2) / 2^F) + add, ties toward plus infinity, saturated
module amst_dot2 (
  input  amst_pkg::elem_t x1,
  input  amst_pkg::elem_t y1,
  input  amst_pkg::elem_t x2,
  input  amst_pkg::elem_t y2,
  input  amst_pkg::elem_t add,
  output amst_pkg::elem_t r,
  output logic            sat
);

  localparam int SH_W = amst_pkg::SUM_W - amst_pkg::FRAC_BITS;
  localparam int HI_W = SH_W - amst_pkg::ELEM_W + 1;

  logic signed [amst_pkg::PROD_W-1:0] p1;
  logic signed [amst_pkg::PROD_W-1:0] p2;
  logic signed [amst_pkg::SUM_W-1:0]  sum;
  logic signed [SH_W-1:0]             shifted;
  logic [HI_W-1:0]                    hi;

  assign p1 = amst_pkg::PROD_W'(x1) * amst_pkg::PROD_W'(y1);
  assign p2 = amst_pkg::PROD_W'(x2) * amst_pkg::PROD_W'(y2);

  assign sum = amst_pkg::SUM_W'(p1) + amst_pkg::SUM_W'(p2)
             + (amst_pkg::SUM_W'(add) <<< amst_pkg::FRAC_BITS)
             + (amst_pkg::SUM_W'(1) <<< (amst_pkg::FRAC_BITS - 1));

  assign shifted = sum[amst_pkg::SUM_W-1:amst_pkg::FRAC_BITS];
  // bits from the result sign up must all agree for the value to fit
  assign hi      = shifted[SH_W-1:amst_pkg::ELEM_W-1];

  always_comb begin
    sat = !((&hi) || !(|hi));
    if (!sat) begin
      r = shifted[amst_pkg::ELEM_W-1:0];
    end else if (shifted[SH_W-1]) begin
      r = {1'b1, {(amst_pkg::ELEM_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(amst_pkg::ELEM_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/amst_stack.sv @@
`timescale 1ns / 1ps

// saved matrices, one register row per level
module amst_stack (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [amst_pkg::PTR_W-1:0] wr_idx,
  input  amst_pkg::mat_t             wr_data,
  input  logic [amst_pkg::PTR_W-1:0] rd_idx,
  output amst_pkg::mat_t             rd_data
);

  amst_pkg::mat_t rows [amst_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows[wr_idx] <= wr_data;
    end
  end

  assign rd_data = rows[rd_idx];

endmodule

@@ rtl/affine_matrix_stack_2d.sv @@
`timescale 1ns / 1ps

// Channel  Role    Payload
// req      sink    cmd, in_a, in_b, in_c, in_d, in_tx, in_ty
// rsp      source  out_a, out_b, out_c, out_d, out_tx, out_ty, level, status
//
// One request per cycle while rsp.ready holds; a request passes the request
// register, then the result register. The append path, six two-term dot
// products off the current matrix register, sets the cycle time.
// rst (synchronous) empties both registers, sets the identity matrix, level 0.
// A stalled result holds the request register; req.ready drops only when both
// are full and rsp.ready is low.
module affine_matrix_stack_2d (
  input  logic        clk,
  input  logic        rst,
  amst_cmd_if.sink    req,
  amst_res_if.source  rsp
);

  // request register
  logic                        q_valid;
  logic [amst_pkg::CMD_W-1:0]  q_cmd;
  amst_pkg::mat_t              q_mat;

  // architectural state
  amst_pkg::mat_t                cur;
  amst_pkg::mat_t                cur_next;
  logic [amst_pkg::LEVEL_W-1:0]  level;
  logic [amst_pkg::LEVEL_W-1:0]  level_next;
  logic [amst_pkg::LEVEL_W-1:0]  level_dec;

  // result register
  logic                          r_valid;
  amst_pkg::mat_t                r_mat;
  logic [amst_pkg::LEVEL_W-1:0]  r_level;
  logic [amst_pkg::STAT_W-1:0]   r_status;
  logic [amst_pkg::STAT_W-1:0]   status_next;

  logic            advance;
  logic            push_en;
  amst_pkg::mat_t  top_row;
  amst_pkg::mat_t  prod;
  logic [5:0]      sat_bits;

  // advance the request into the result register when that slot frees up
  assign advance   = q_valid && (!r_valid || rsp.ready);
  assign req.ready = !q_valid || advance;
  assign level_dec = level - amst_pkg::LEVEL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req.ready) begin
      q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      q_cmd <= req.cmd;
      q_mat <= '{a: req.in_a, b: req.in_b, c: req.in_c, d: req.in_d,
                 tx: req.in_tx, ty: req.in_ty};
    end
  end

  amst_stack u_stack (
    .clk     (clk),
    .wr_en   (push_en),
    .wr_idx  (level[amst_pkg::PTR_W-1:0]),
    .wr_data (cur),
    .rd_idx  (level_dec[amst_pkg::PTR_W-1:0]),
    .rd_data (top_row)
  );

  // G * M: given matrix on the left, current matrix on the right
  amst_dot2 u_dot_a (.x1(q_mat.a), .y1(cur.a), .x2(q_mat.b), .y2(cur.c),
                     .add(amst_pkg::FX_ZERO), .r(prod.a), .sat(sat_bits[0]));
  amst_dot2 u_dot_b (.x1(q_mat.a), .y1(cur.b), .x2(q_mat.b), .y2(cur.d),
                     .add(amst_pkg::FX_ZERO), .r(prod.b), .sat(sat_bits[1]));
  amst_dot2 u_dot_c (.x1(q_mat.c), .y1(cur.a), .x2(q_mat.d), .y2(cur.c),
                     .add(amst_pkg::FX_ZERO), .r(prod.c), .sat(sat_bits[2]));
  amst_dot2 u_dot_d (.x1(q_mat.c), .y1(cur.b), .x2(q_mat.d), .y2(cur.d),
                     .add(amst_pkg::FX_ZERO), .r(prod.d), .sat(sat_bits[3]));
  amst_dot2 u_dot_tx (.x1(q_mat.tx), .y1(cur.a), .x2(q_mat.ty), .y2(cur.c),
                      .add(cur.tx), .r(prod.tx), .sat(sat_bits[4]));
  amst_dot2 u_dot_ty (.x1(q_mat.tx), .y1(cur.b), .x2(q_mat.ty), .y2(cur.d),
                      .add(cur.ty), .r(prod.ty), .sat(sat_bits[5]));

  // command decode; unused codes behave as get
  always_comb begin
    cur_next    = cur;
    level_next  = level;
    status_next = amst_pkg::ST_OK;
    push_en     = 1'b0;
    case (q_cmd)
      amst_pkg::CMD_PUSH: begin
        if (level != amst_pkg::LEVEL_FULL) begin
          push_en    = advance;
          level_next = level + amst_pkg::LEVEL_W'(1);
        end else begin
          status_next = amst_pkg::ST_OVERFLOW;
        end
      end
      amst_pkg::CMD_POP: begin
        if (level != '0) begin
          level_next = level_dec;
          cur_next   = top_row;
        end else begin
          status_next = amst_pkg::ST_UNDERFLW;
        end
      end
      amst_pkg::CMD_SET: begin
        cur_next = q_mat;
      end
      amst_pkg::CMD_APPEND: begin
        cur_next = prod;
        if (|sat_bits) begin
          status_next = amst_pkg::ST_SAT;
        end
      end
      amst_pkg::CMD_GET: begin
        cur_next = cur;
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur   <= amst_pkg::MAT_IDENTITY;
      level <= '0;
    end else if (advance) begin
      cur   <= cur_next;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= 1'b1;
    end else if (rsp.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_mat    <= cur_next;
      r_level  <= level_next;
      r_status <= status_next;
    end
  end

  assign rsp.valid  = r_valid;
  assign rsp.out_a  = r_mat.a;
  assign rsp.out_b  = r_mat.b;
  assign rsp.out_c  = r_mat.c;
  assign rsp.out_d  = r_mat.d;
  assign rsp.out_tx = r_mat.tx;
  assign rsp.out_ty = r_mat.ty;
  assign rsp.level  = r_level;
  assign rsp.status = r_status;

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= amst_pkg::LEVEL_FULL)
    else $error("stack level above depth");

  a_push_step: assert property (@(posedge clk) disable iff (rst)
    advance && q_cmd == amst_pkg::CMD_PUSH && level != amst_pkg::LEVEL_FULL
    |=> level == $past(level) + amst_pkg::LEVEL_W'(1))
    else $error("push did not raise level");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == amst_pkg::ST_OVERFLOW |-> rsp.level == amst_pkg::LEVEL_FULL)
    else $error("overflow reported below full");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == amst_pkg::ST_UNDERFLW |-> rsp.level == '0)
    else $error("underflow reported on nonempty stack");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid && !rsp.ready && q_valid)
    else $error("request stalled without a blocked result");
`endif

endmodule

@@ test/affine_matrix_stack_2d_checker.sv @@
`timescale 1ns / 1ps

module affine_matrix_stack_2d_checker (
  input  logic       clk,
  input  logic       rst,
  amst_cmd_if        req,
  amst_res_if        rsp,
  output int         reports_due,
  output int         mismatches,
  output int         reports_checked,
  output int         peak_level,
  output logic [3:0] statuses_seen
);

  import amst_pkg::*;

  // room for the exact sum of two full products plus the rounding half
  localparam int ACC_W = 2 * ELEM_W + 4;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
  localparam elem_t ELEM_TOP    = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t ELEM_BOTTOM = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct {
    mat_t               m;
    logic [LEVEL_W-1:0] level;
    logic [STAT_W-1:0]  status;
  } matrix_report_t;

  matrix_report_t     awaited_reports [$];
  mat_t               cur_matrix;
  mat_t               saved_stack [STACK_DEPTH];
  logic [LEVEL_W-1:0] stack_fill;

  // round-half-up of (x1*y1 + x2*y2) / 2^FRAC_BITS, plus add, clamped to 32 bits
  function automatic elem_t compose_element(elem_t x1, elem_t y1, elem_t x2, elem_t y2,
                                            elem_t add, inout logic sat);
    logic signed [ACC_W-1:0] acc;
    acc = ACC_W'(x1) * ACC_W'(y1) + ACC_W'(x2) * ACC_W'(y2) + ROUND_HALF;
    acc = (acc >>> FRAC_BITS) + ACC_W'(add);
    if (acc > ACC_W'(ELEM_TOP)) begin
      sat = 1'b1;
      return ELEM_TOP;
    end
    if (acc < ACC_W'(ELEM_BOTTOM)) begin
      sat = 1'b1;
      return ELEM_BOTTOM;
    end
    return elem_t'(acc[ELEM_W-1:0]);
  endfunction

  function automatic matrix_report_t apply_command(logic [CMD_W-1:0] code, mat_t given);
    matrix_report_t rep;
    mat_t           m;
    logic           sat;
    rep.status = ST_OK;
    sat = 1'b0;
    m = cur_matrix;
    case (code)
      CMD_PUSH: begin
        if (stack_fill < LEVEL_FULL) begin
          saved_stack[stack_fill[PTR_W-1:0]] = cur_matrix;
          stack_fill = stack_fill + 1'b1;
        end else begin
          rep.status = ST_OVERFLOW;
        end
      end
      CMD_POP: begin
        if (stack_fill != '0) begin
          stack_fill = stack_fill - 1'b1;
          cur_matrix = saved_stack[stack_fill[PTR_W-1:0]];
        end else begin
          rep.status = ST_UNDERFLW;
        end
      end
      CMD_SET: cur_matrix = given;
      CMD_APPEND: begin
        cur_matrix.a  = compose_element(given.a,  m.a, given.b,  m.c, FX_ZERO, sat);
        cur_matrix.b  = compose_element(given.a,  m.b, given.b,  m.d, FX_ZERO, sat);
        cur_matrix.c  = compose_element(given.c,  m.a, given.d,  m.c, FX_ZERO, sat);
        cur_matrix.d  = compose_element(given.c,  m.b, given.d,  m.d, FX_ZERO, sat);
        cur_matrix.tx = compose_element(given.tx, m.a, given.ty, m.c, m.tx,    sat);
        cur_matrix.ty = compose_element(given.tx, m.b, given.ty, m.d, m.ty,    sat);
        if (sat) begin
          rep.status = ST_SAT;
        end
      end
      default: ;  // get and the spare codes only report
    endcase
    rep.m = cur_matrix;
    rep.level = stack_fill;
    return rep;
  endfunction

  task automatic check_field(string field, logic signed [63:0] want, logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    matrix_report_t want;
    mat_t           given;
    if (rst) begin
      cur_matrix = MAT_IDENTITY;
      stack_fill = '0;
      awaited_reports.delete();
      mismatches = 0;
      reports_checked = 0;
      peak_level = 0;
      statuses_seen = '0;
    end else begin
      if (req.valid && req.ready) begin
        given = '{a: req.in_a, b: req.in_b, c: req.in_c, d: req.in_d,
                  tx: req.in_tx, ty: req.in_ty};
        awaited_reports.push_back(apply_command(req.cmd, given));
      end
      if (rsp.valid && rsp.ready) begin
        if (awaited_reports.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("out_a",  want.m.a,   rsp.out_a);
          check_field("out_b",  want.m.b,   rsp.out_b);
          check_field("out_c",  want.m.c,   rsp.out_c);
          check_field("out_d",  want.m.d,   rsp.out_d);
          check_field("out_tx", want.m.tx,  rsp.out_tx);
          check_field("out_ty", want.m.ty,  rsp.out_ty);
          check_field("level",  want.level, rsp.level);
          check_field("status", want.status, rsp.status);
          reports_checked++;
          statuses_seen[want.status] = 1'b1;
          if (int'(want.level) > peak_level) begin
            peak_level = int'(want.level);
          end
        end
      end
    end
    reports_due = awaited_reports.size();
  end

endmodule

@@ test/affine_matrix_stack_2d_tb.sv @@
`timescale 1ns / 1ps

module affine_matrix_stack_2d_tb;

  import amst_pkg::*;

  localparam int RANDOM_REQUESTS = 1200;
  localparam int IDLE_LIMIT      = 3000;  // cycles with no handshake on either side
  localparam int LONG_HOLD       = 150;   // receiver hold-off that backs the block up
  localparam int DRAIN_CYCLES    = 10;    // two-stage pipe, plenty of margin

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam elem_t ELEM_TOP    = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam elem_t ELEM_BOTTOM = {1'b1, {(ELEM_W-1){1'b0}}};
  localparam elem_t FX_HALF     = FX_ONE >>> 1;
  localparam int    SMALL_SPAN  = 2 * FX_ONE;   // small values stay within +/-2.0

  typedef enum logic [1:0] {MIX_BALANCED, MIX_FILL, MIX_DRAIN} stack_mix_t;

  logic clk;
  logic rst;

  int requests_sent;
  int long_holds_asked;

  int         reports_due;
  int         mismatches;
  int         reports_checked;
  int         peak_level;
  logic [3:0] statuses_seen;

  amst_cmd_if req ();
  amst_res_if rsp ();

  affine_matrix_stack_2d dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // The checker sees every handshake on both channels, runs its own copy of
  // the matrix and stack, and reports back how many results are still owed
  // and how many fields came back wrong.
  affine_matrix_stack_2d_checker matrix_check (
    .clk             (clk),
    .rst             (rst),
    .req             (req),
    .rsp             (rsp),
    .reports_due     (reports_due),
    .mismatches      (mismatches),
    .reports_checked (reports_checked),
    .peak_level      (peak_level),
    .statuses_seen   (statuses_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic mat_t mat_of(elem_t a, elem_t b, elem_t c, elem_t d,
                                  elem_t tx, elem_t ty);
    mat_t m;
    m = '{a: a, b: b, c: c, d: d, tx: tx, ty: ty};
    return m;
  endfunction

  // Mostly small values so that chains of appends stay mostly in range,
  // with values near one, raw 32-bit noise, the extremes and plus or minus one half
  // mixed in so that saturation and rounding ties keep showing up.
  function automatic elem_t pick_element();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) begin
      return elem_t'(int'($urandom_range(2 * SMALL_SPAN)) - SMALL_SPAN);
    end else if (sel < 70) begin
      return FX_ONE + elem_t'(int'($urandom_range(4095)) - 2048);
    end else if (sel < 82) begin
      return elem_t'($urandom());
    end else if (sel < 92) begin
      case ($urandom_range(4))
        0:       return ELEM_TOP;
        1:       return ELEM_BOTTOM;
        2:       return FX_ZERO;
        3:       return -elem_t'(1);
        default: return elem_t'(1);
      endcase
    end
    return $urandom_range(1) ? FX_HALF : -FX_HALF;
  endfunction

  function automatic mat_t pick_matrix();
    mat_t m;
    m.a  = pick_element();
    m.b  = pick_element();
    m.c  = pick_element();
    m.d  = pick_element();
    m.tx = pick_element();
    m.ty = pick_element();
    return m;
  endfunction

  // Fill phases lean on push to hit overflow, drain phases on pop to hit
  // underflow; the rest is set, append, get and the spare codes.
  function automatic logic [CMD_W-1:0] pick_command(stack_mix_t mix);
    int unsigned sel;
    int unsigned push_w;
    int unsigned pop_w;
    int unsigned rest;
    case (mix)
      MIX_FILL: begin
        push_w = 45;
        pop_w  = 5;
      end
      MIX_DRAIN: begin
        push_w = 5;
        pop_w  = 45;
      end
      default: begin
        push_w = 25;
        pop_w  = 25;
      end
    endcase
    sel = $urandom_range(99);
    if (sel < push_w) return CMD_PUSH;
    if (sel < push_w + pop_w) return CMD_POP;
    rest = sel - push_w - pop_w;
    if (rest < 12) return CMD_SET;
    if (rest < 40) return CMD_APPEND;
    if (rest < 46) return CMD_GET;
    return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
  endfunction

  // Drive one request at the falling edge and hold it until accepted. Valid is
  // left high on return so that back-to-back requests keep it asserted.
  task automatic send_request(input logic [CMD_W-1:0] code, input mat_t given);
    req.valid = 1'b1;
    req.cmd   = code;
    req.in_a  = given.a;
    req.in_b  = given.b;
    req.in_c  = given.c;
    req.in_d  = given.d;
    req.in_tx = given.tx;
    req.in_ty = given.ty;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic hold_off(input int cycles);
    req.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding request to come back.
  task automatic wait_for_results();
    req.valid = 1'b0;
    while (reports_due != 0) @(negedge clk);
  endtask

  // Receiver: runs of random length, each with its own stall rate, some of
  // them with no stalls at all. When the sender asks for it, hold ready low
  // for a long stretch so the result and request registers both fill.
  initial begin : result_drain
    int stall_pct;
    int seg_left;
    int hold_left;
    int holds_done;
    rsp.ready  = 1'b0;
    stall_pct  = 0;
    seg_left   = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (long_holds_asked > holds_done) begin
        holds_done++;
        hold_left = LONG_HOLD;
        rsp.ready = 1'b0;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        case ($urandom_range(4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      rsp.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst && ((req.valid && req.ready) || (rsp.valid && rsp.ready))) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    mat_t             given;
    logic [CMD_W-1:0] code;
    stack_mix_t       mix;
    int               mix_left;
    int               burst_left;
    int               gap;

    requests_sent    = 0;
    long_holds_asked = 0;
    rst       = 1'b1;
    req.valid = 1'b0;
    req.cmd   = CMD_GET;
    req.in_a  = FX_ZERO;
    req.in_b  = FX_ZERO;
    req.in_c  = FX_ZERO;
    req.in_d  = FX_ZERO;
    req.in_tx = FX_ZERO;
    req.in_ty = FX_ZERO;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part.
    // Report the reset matrix, then pop an empty stack.
    send_request(CMD_GET, mat_of(FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO));
    send_request(CMD_POP, pick_matrix());
    // Save the identity, then drive every element to the positive and the
    // negative clamp.
    send_request(CMD_PUSH, pick_matrix());
    send_request(CMD_SET, mat_of(ELEM_TOP, ELEM_TOP, ELEM_TOP, ELEM_TOP, ELEM_TOP, ELEM_TOP));
    send_request(CMD_APPEND,
                 mat_of(ELEM_TOP, ELEM_TOP, ELEM_TOP, ELEM_TOP, ELEM_TOP, ELEM_TOP));
    send_request(CMD_SET, mat_of(ELEM_BOTTOM, ELEM_BOTTOM, ELEM_BOTTOM, ELEM_BOTTOM,
                                 ELEM_BOTTOM, ELEM_BOTTOM));
    send_request(CMD_APPEND,
                 mat_of(ELEM_TOP, ELEM_TOP, ELEM_TOP, ELEM_TOP, ELEM_TOP, ELEM_TOP));
    // A get ignores its payload, even with every bit set.
    send_request(CMD_GET, mat_of(-elem_t'(1), -elem_t'(1), -elem_t'(1), -elem_t'(1),
                                 -elem_t'(1), -elem_t'(1)));
    send_request(CMD_POP, pick_matrix());
    // Rounding ties: products of exactly +0.5 and -0.5 LSB, with translation.
    send_request(CMD_SET, mat_of(elem_t'(1), -elem_t'(1), FX_ZERO, FX_ZERO,
                                 elem_t'(5), -elem_t'(5)));
    send_request(CMD_APPEND, mat_of(FX_HALF, FX_ZERO, -FX_HALF, FX_ZERO, FX_HALF, -FX_HALF));
    // Extreme operand on a tiny matrix, no clamp expected.
    send_request(CMD_APPEND,
                 mat_of(ELEM_BOTTOM, ELEM_BOTTOM, ELEM_TOP, ELEM_TOP, ELEM_BOTTOM, ELEM_TOP));
    // The identity on either side of an append gives the other matrix back.
    send_request(CMD_SET, MAT_IDENTITY);
    send_request(CMD_APPEND, mat_of(32'sh12345678, 32'shEDCBA987, 32'sh7FFF0001,
                                    32'sh80010000, 32'sh00000001, 32'shFFFFFFFF));
    send_request(CMD_PUSH, pick_matrix());
    send_request(CMD_SET, mat_of(32'sh00018000, 32'shFFFF4000, 32'sh00000003,
                                 32'shFFFFFFFD, 32'sh7FFFFFFF, 32'sh80000000));
    send_request(CMD_APPEND, MAT_IDENTITY);
    send_request(CMD_POP, pick_matrix());
    // Spare codes behave as get.
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
      send_request(CMD_W'(c), pick_matrix());
    end
    // Append onto the zero matrix.
    send_request(CMD_SET, mat_of(FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO, FX_ZERO));
    send_request(CMD_APPEND, pick_matrix());
    wait_for_results();

    // Random part: bursts of requests with gaps, stack phases that fill and
    // drain, two long receiver hold-offs and one full drain in the middle.
    mix_left   = 0;
    burst_left = 0;
    mix        = MIX_BALANCED;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS / 4 || n == 3 * RANDOM_REQUESTS / 4) begin
        long_holds_asked++;
        burst_left = LONG_HOLD + 50;  // keep offering while the receiver holds off
      end
      if (n == RANDOM_REQUESTS / 2) begin
        wait_for_results();
      end
      if (mix_left == 0) begin
        mix      = stack_mix_t'($urandom_range(2));
        mix_left = $urandom_range(20, 60);
      end
      mix_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          hold_off(gap);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      code  = pick_command(mix);
      given = pick_matrix();
      send_request(code, given);
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d requests, checked %0d results, %0d field mismatches.",
             requests_sent, reports_checked, mismatches);
    $display("Deepest stack level %0d of %0d; statuses seen (sat,under,over,ok) = %b.",
             peak_level, STACK_DEPTH, statuses_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/amst_pkg.sv
rtl/amst_cmd_if.sv
rtl/amst_res_if.sv
rtl/amst_dot2.sv
rtl/amst_stack.sv
rtl/affine_matrix_stack_2d.sv
test/affine_matrix_stack_2d_checker.sv
test/affine_matrix_stack_2d_tb.sv
